// ===== hw/rtl/nrps_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nrps_pkg
// Shared codes and controller/datapath handshake types for the nearest
// reference point search block.
// ----------------------------------------------------------------------------
package nrps_pkg;

    // Operation codes carried by the func field of an input item.
    localparam logic [1:0] FUNC_LOAD     = 2'd0;
    localparam logic [1:0] FUNC_QUERY    = 2'd1;
    localparam logic [1:0] FUNC_DEFAULTS = 2'd2;
    localparam logic [1:0] FUNC_UNUSED   = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] CFG_BOUND_MIN_X = 2'd0;
    localparam logic [1:0] CFG_BOUND_MIN_Y = 2'd1;
    localparam logic [1:0] CFG_BOUND_MAX_X = 2'd2;
    localparam logic [1:0] CFG_BOUND_MAX_Y = 2'd3;

    // Number of entries installed by a defaults item.
    localparam int DEF_POINTS = 4;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       load;         // append the input item to the table
        logic       query_start;  // latch the query point, rewind the scan
        logic       def_write;    // write one default entry
        logic [1:0] def_idx;      // which default entry
        logic       scan_issue;   // read the next table entry
        logic       out_load;     // move the result into the output register
    } nrps_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic table_empty;  // no entries stored
        logic scan_last;    // the scan address points at the last entry
        logic pipe_busy;    // distance pipeline still holds entries
        logic out_free;     // output register can take a new result
    } nrps_status_t;

endpackage

// ===== hw/rtl/nrps_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nrps_ram
// Simple dual-port RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module nrps_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/nrps_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nrps_ctrl
// Controller: accepts items, sequences the default install, the table scan
// and the hand-off of a query result to the output register.
// ----------------------------------------------------------------------------
module nrps_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [1:0]            s_func,
    input  nrps_pkg::nrps_status_t status,
    output nrps_pkg::nrps_cmd_t    cmd
);
    import nrps_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_DEFS  = 3'd1;
    localparam logic [2:0] ST_SCAN  = 3'd2;
    localparam logic [2:0] ST_DRAIN = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    logic [2:0] state_reg, state_next;
    logic [1:0] def_idx_reg, def_idx_next;
    logic       accept;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    // Next state and command decode.
    always_comb begin
        state_next   = state_reg;
        def_idx_next = def_idx_reg;
        cmd          = '0;
        cmd.def_idx  = def_idx_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (s_func)
                        FUNC_LOAD: begin
                            cmd.load = 1'b1;
                        end
                        FUNC_QUERY: begin
                            cmd.query_start = 1'b1;
                            state_next = status.table_empty ? ST_DONE : ST_SCAN;
                        end
                        FUNC_DEFAULTS: begin
                            def_idx_next = '0;
                            state_next   = ST_DEFS;
                        end
                        FUNC_UNUSED: begin
                            state_next = ST_IDLE;
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_DEFS: begin
                cmd.def_write = 1'b1;
                def_idx_next  = def_idx_reg + 2'd1;
                if (def_idx_reg == 2'(DEF_POINTS - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_SCAN: begin
                cmd.scan_issue = 1'b1;
                if (status.scan_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!status.pipe_busy) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            def_idx_reg <= '0;
        end else begin
            state_reg   <= state_next;
            def_idx_reg <= def_idx_next;
        end
    end

endmodule

// ===== hw/rtl/nrps_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nrps_datapath
// Datapath: bound registers, entry table, default point generator,
// pipelined squared-distance scan with running minimum, output register.
// ----------------------------------------------------------------------------
module nrps_datapath #(
    parameter int MAX_POINTS = 64,
    parameter int COORD_BITS = 16
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_wr_en,
    input  logic [1:0]                            cfg_index,
    input  logic [COORD_BITS-1:0]                 cfg_wr_data,
    input  logic signed [COORD_BITS-1:0]          s_coord_x,
    input  logic signed [COORD_BITS-1:0]          s_coord_y,
    input  logic [15:0]                           s_point_id,
    input  logic                                  s_first_of_load,
    input  nrps_pkg::nrps_cmd_t                    cmd,
    output nrps_pkg::nrps_status_t                 status,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [$clog2(MAX_POINTS)-1:0]         m_best_index,
    output logic [15:0]                           m_best_id,
    output logic signed [COORD_BITS-1:0]          m_best_x,
    output logic signed [COORD_BITS-1:0]          m_best_y,
    output logic [2*COORD_BITS:0]                 m_best_dist_sq,
    output logic                                  m_table_empty
);
    import nrps_pkg::*;

    localparam int CB      = COORD_BITS;
    localparam int IDX_W   = $clog2(MAX_POINTS);
    localparam int CNT_W   = $clog2(MAX_POINTS + 1);
    localparam int ENTRY_W = 2 * CB + 16;
    localparam int SQ_W    = 2 * CB;
    localparam int DIST_W  = 2 * CB + 1;
    localparam int SAT_W   = (DIST_W > 64) ? 64 : DIST_W;
    localparam bit CAN_SAT = (DIST_W > 64);
    localparam logic [DIST_W-1:0] SAT_VAL = {DIST_W{1'b1}} >> (DIST_W - SAT_W);
    localparam logic [CB-1:0] COORD_MIN = {1'b1, {(CB - 1){1'b0}}};
    localparam logic [CB-1:0] COORD_MAX = {1'b0, {(CB - 1){1'b1}}};

    // ------------------------------------------------------------------
    // Bound registers.
    // ------------------------------------------------------------------
    logic signed [CB-1:0] min_x_reg, min_y_reg, max_x_reg, max_y_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_x_reg <= COORD_MIN;
            min_y_reg <= COORD_MIN;
            max_x_reg <= COORD_MAX;
            max_y_reg <= COORD_MAX;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_BOUND_MIN_X: min_x_reg <= cfg_wr_data;
                CFG_BOUND_MIN_Y: min_y_reg <= cfg_wr_data;
                CFG_BOUND_MAX_X: max_x_reg <= cfg_wr_data;
                CFG_BOUND_MAX_Y: max_y_reg <= cfg_wr_data;
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Default points: quarter positions, division truncating toward zero.
    // ------------------------------------------------------------------
    logic signed [CB:0] span_x, span_y, q_x, q_y;
    logic signed [CB:0] lo_x, hi_x, lo_y, hi_y;
    logic [CB-1:0]      def_x, def_y;

    always_comb begin
        span_x = $signed({max_x_reg[CB-1], max_x_reg}) - $signed({min_x_reg[CB-1], min_x_reg});
        span_y = $signed({max_y_reg[CB-1], max_y_reg}) - $signed({min_y_reg[CB-1], min_y_reg});
        q_x = (span_x + (span_x[CB] ? (CB+1)'(3) : (CB+1)'(0))) >>> 2;
        q_y = (span_y + (span_y[CB] ? (CB+1)'(3) : (CB+1)'(0))) >>> 2;
        lo_x = $signed({min_x_reg[CB-1], min_x_reg}) + q_x;
        hi_x = $signed({max_x_reg[CB-1], max_x_reg}) - q_x;
        lo_y = $signed({min_y_reg[CB-1], min_y_reg}) + q_y;
        hi_y = $signed({max_y_reg[CB-1], max_y_reg}) - q_y;
        def_x = cmd.def_idx[0] ? hi_x[CB-1:0] : lo_x[CB-1:0];
        def_y = cmd.def_idx[1] ? lo_y[CB-1:0] : hi_y[CB-1:0];
    end

    // ------------------------------------------------------------------
    // Entry count and table write port.
    // ------------------------------------------------------------------
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic [ENTRY_W-1:0] wr_data;

    always_comb begin
        count_next = count_reg;
        wr_en      = 1'b0;
        wr_addr    = count_reg[IDX_W-1:0];
        wr_data    = {s_point_id, s_coord_y, s_coord_x};
        if (cmd.load) begin
            if (s_first_of_load) begin
                wr_en      = 1'b1;
                wr_addr    = '0;
                count_next = CNT_W'(1);
            end else if (count_reg < CNT_W'(MAX_POINTS)) begin
                wr_en      = 1'b1;
                count_next = count_reg + CNT_W'(1);
            end
        end else if (cmd.def_write) begin
            wr_en      = 1'b1;
            wr_addr    = IDX_W'(cmd.def_idx);
            wr_data    = {16'(cmd.def_idx), def_y, def_x};
            count_next = CNT_W'(DEF_POINTS);
        end
    end

    // ------------------------------------------------------------------
    // Query point, scan address and empty flag.
    // ------------------------------------------------------------------
    logic signed [CB-1:0] qx_reg, qy_reg;
    logic [IDX_W-1:0]     addr_reg;
    logic                 empty_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            addr_reg  <= '0;
            empty_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            if (cmd.query_start) begin
                addr_reg  <= '0;
                empty_reg <= (count_reg == '0);
            end else if (cmd.scan_issue) begin
                addr_reg <= addr_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.query_start) begin
            qx_reg <= s_coord_x;
            qy_reg <= s_coord_y;
        end
    end

    // Entry table.
    logic [ENTRY_W-1:0] rd_data;

    nrps_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_POINTS)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (cmd.scan_issue),
        .rd_addr (addr_reg),
        .rd_data (rd_data)
    );

    // ------------------------------------------------------------------
    // Distance pipeline: read, absolute differences, squares, minimum.
    // ------------------------------------------------------------------
    logic                 v1_reg, v2_reg, v3_reg;
    logic [IDX_W-1:0]     idx1_reg, idx2_reg, idx3_reg;
    logic [ENTRY_W-1:0]   ent2_reg, ent3_reg;
    logic [CB-1:0]        adx_reg, ady_reg;
    logic [SQ_W-1:0]      sqx_reg, sqy_reg;
    logic signed [CB-1:0] ex1, ey1;
    logic signed [CB:0]   dx1, dy1;
    logic [CB:0]          adx1, ady1;

    always_comb begin
        ex1  = rd_data[CB-1:0];
        ey1  = rd_data[2*CB-1:CB];
        dx1  = $signed({qx_reg[CB-1], qx_reg}) - $signed({ex1[CB-1], ex1});
        dy1  = $signed({qy_reg[CB-1], qy_reg}) - $signed({ey1[CB-1], ey1});
        adx1 = dx1[CB] ? (CB+1)'(-dx1) : (CB+1)'(dx1);
        ady1 = dy1[CB] ? (CB+1)'(-dy1) : (CB+1)'(dy1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v1_reg <= cmd.scan_issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        idx1_reg <= addr_reg;
        idx2_reg <= idx1_reg;
        ent2_reg <= rd_data;
        adx_reg  <= adx1[CB-1:0];
        ady_reg  <= ady1[CB-1:0];
        idx3_reg <= idx2_reg;
        ent3_reg <= ent2_reg;
        sqx_reg  <= SQ_W'(adx_reg) * SQ_W'(adx_reg);
        sqy_reg  <= SQ_W'(ady_reg) * SQ_W'(ady_reg);
    end

    // Sum of squares, saturated at 64 ones for the widest coordinates.
    logic [DIST_W-1:0] sum3, dist3;
    logic              sat_hit;

    always_comb begin
        sum3    = {1'b0, sqx_reg} + {1'b0, sqy_reg};
        sat_hit = CAN_SAT && ((sum3 >> 64) != '0);
        dist3   = sat_hit ? SAT_VAL : sum3;
    end

    // Running minimum; the first minimum is kept on ties.
    logic [DIST_W-1:0]  best_d_reg;
    logic [IDX_W-1:0]   best_idx_reg;
    logic [ENTRY_W-1:0] best_ent_reg;

    always_ff @(posedge aclk) begin
        if (v3_reg && ((idx3_reg == '0) || (dist3 < best_d_reg))) begin
            best_d_reg   <= dist3;
            best_idx_reg <= idx3_reg;
            best_ent_reg <= ent3_reg;
        end
    end

    // ------------------------------------------------------------------
    // Output register.
    // ------------------------------------------------------------------
    logic                 m_valid_reg;
    logic [IDX_W-1:0]     out_idx_reg;
    logic [15:0]          out_id_reg;
    logic [CB-1:0]        out_x_reg, out_y_reg;
    logic [DIST_W-1:0]    out_d_reg;
    logic                 out_empty_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            if (empty_reg) begin
                out_idx_reg   <= '0;
                out_id_reg    <= '0;
                out_x_reg     <= '0;
                out_y_reg     <= '0;
                out_d_reg     <= '0;
                out_empty_reg <= 1'b1;
            end else begin
                out_idx_reg   <= best_idx_reg;
                out_id_reg    <= best_ent_reg[ENTRY_W-1:2*CB];
                out_x_reg     <= best_ent_reg[CB-1:0];
                out_y_reg     <= best_ent_reg[2*CB-1:CB];
                out_d_reg     <= best_d_reg;
                out_empty_reg <= 1'b0;
            end
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_best_index   = out_idx_reg;
    assign m_best_id      = out_id_reg;
    assign m_best_x       = out_x_reg;
    assign m_best_y       = out_y_reg;
    assign m_best_dist_sq = out_d_reg;
    assign m_table_empty  = out_empty_reg;

    // Status to the controller.
    always_comb begin
        status.table_empty = (count_reg == '0);
        status.scan_last   = ((CNT_W'(addr_reg) + CNT_W'(1)) == count_reg);
        status.pipe_busy   = v1_reg || v2_reg || v3_reg;
        status.out_free    = !m_valid_reg || m_ready;
    end

endmodule

// ===== hw/rtl/nearest_reference_point_search.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_reference_point_search
// Table of 2-D reference points answering nearest-point queries by a
// linear scan over squared Euclidean distance.
// ----------------------------------------------------------------------------
// A load item is accepted while the block stays idle and ready. A defaults
// item is accepted and then makes four table writes before the block is
// ready again. A query leaves the block ready again in the same cycle that
// its result enters the output register. The entry memory has one read
// port, so the scan reads one entry per cycle. The scan then drains through
// the read, difference and square stages to the last compare, and the
// result then moves into the output register. A query on an empty table
// skips the scan. If a finished result finds the output register still
// occupied, the block waits until that result is taken. The block handles
// one item at a time, but it accepts load and defaults items while a result
// is still waiting in the output register. Ties go to the lower table
// position.
// ----------------------------------------------------------------------------
module nearest_reference_point_search #(
    parameter int MAX_POINTS = 64,
    parameter int COORD_BITS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Configuration write port.
    input  logic                          cfg_wr_en,
    input  logic [1:0]                    cfg_index,
    input  logic [COORD_BITS-1:0]         cfg_wr_data,
    // Input items.
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [1:0]                    s_func,
    input  logic signed [COORD_BITS-1:0]  s_coord_x,
    input  logic signed [COORD_BITS-1:0]  s_coord_y,
    input  logic [15:0]                   s_point_id,
    input  logic                          s_first_of_load,
    // Result items.
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [$clog2(MAX_POINTS)-1:0] m_best_index,
    output logic [15:0]                   m_best_id,
    output logic signed [COORD_BITS-1:0]  m_best_x,
    output logic signed [COORD_BITS-1:0]  m_best_y,
    output logic [2*COORD_BITS:0]         m_best_dist_sq,
    output logic                          m_table_empty
);
    import nrps_pkg::*;

    nrps_cmd_t    cmd;
    nrps_status_t status;

    // Sequencing of items.
    nrps_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_func  (s_func),
        .status  (status),
        .cmd     (cmd)
    );

    // Storage, distance pipeline and output register.
    nrps_datapath #(
        .MAX_POINTS (MAX_POINTS),
        .COORD_BITS (COORD_BITS)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wr_data     (cfg_wr_data),
        .s_coord_x       (s_coord_x),
        .s_coord_y       (s_coord_y),
        .s_point_id      (s_point_id),
        .s_first_of_load (s_first_of_load),
        .cmd             (cmd),
        .status          (status),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_best_index    (m_best_index),
        .m_best_id       (m_best_id),
        .m_best_x        (m_best_x),
        .m_best_y        (m_best_y),
        .m_best_dist_sq  (m_best_dist_sq),
        .m_table_empty   (m_table_empty)
    );

endmodule
